[rtl/core/fsgs_pkg.sv]
// ----------------------------------------------------------------------------
// fsgs_pkg
// shared constants, payload words and sequencer states for the sand grid
// ----------------------------------------------------------------------------
package fsgs_pkg;

	localparam int GRID_WIDTH  = 64;
	localparam int GRID_HEIGHT = 64;
	localparam int CELL_COUNT  = GRID_WIDTH * GRID_HEIGHT;
	localparam int ADDR_W      = $clog2(CELL_COUNT);
	localparam int COL_W       = $clog2(GRID_WIDTH);
	localparam int CELL_ADDR_W = 12;
	localparam int CMP_W       = ((ADDR_W > CELL_ADDR_W) ? ADDR_W : CELL_ADDR_W) + 1;
	localparam int KIND_W      = 2;
	localparam int SEED_W      = 16;
	localparam int APB_ADDR_W  = 3;
	localparam int APB_DATA_W  = 32;

	localparam logic [SEED_W-1:0] SEED_RESET = 16'd44257;

	// cell kinds
	localparam logic [KIND_W-1:0] KIND_AIR   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SAND  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_WATER = 2'd2;
	localparam logic [KIND_W-1:0] KIND_ROCK  = 2'd3;

	// opcodes
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_SWEEP = 2'd2;

	// register word indexes
	localparam logic REG_SEED = 1'b0;

	typedef struct packed {
		logic [1:0]             opcode;
		logic [CELL_ADDR_W-1:0] cell_address;
		logic [KIND_W-1:0]      cell_kind_in;
	} in_word_t;

	typedef struct packed {
		logic [KIND_W-1:0] cell_kind_out;
		logic              command_done;
	} out_word_t;

	typedef struct packed {
		logic ready;
		logic res_valid;
	} eng_stat_t;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_RD_WAIT,
		ST_CLR,
		ST_CUR_RD,
		ST_CUR_EV,
		ST_BEL_EV,
		ST_SIDE_EV,
		ST_WR_SRC,
		ST_DONE
	} eng_state_t;

endpackage

[rtl/core/fsgs_ram.sv]
// ----------------------------------------------------------------------------
// fsgs_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module fsgs_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 4096,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[rtl/core/fsgs_engine.sv]
// ----------------------------------------------------------------------------
// fsgs_engine
// command sequencer: cell read and write, mark clear and the update sweep
// ----------------------------------------------------------------------------
module fsgs_engine
	import fsgs_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  in_word_t          cmd,
	input  logic              res_take,
	input  logic              lfsr_load,
	input  logic [SEED_W-1:0] seed,
	output eng_stat_t         stat,
	output out_word_t         res
);

	typedef struct packed {
		logic [ADDR_W-1:0] first;
		logic [ADDR_W-1:0] second;
		logic              two;
		logic              step;
	} side_t;

	function automatic logic lfsr_bit(input logic [SEED_W-1:0] s);
		lfsr_bit = s[0] ^ s[2] ^ s[3] ^ s[5];
	endfunction

	function automatic side_t side_pick(input logic [ADDR_W-1:0] base,
			input logic [COL_W-1:0] col, input logic [SEED_W-1:0] s);
		side_t p;
		p.first  = base + ADDR_W'(1);
		p.second = base - ADDR_W'(1);
		p.two    = 1'b0;
		p.step   = 1'b0;
		if (col == COL_W'(0)) begin
			p.first = base + ADDR_W'(1);
		end else if (col == COL_W'(GRID_WIDTH - 1)) begin
			p.first = base - ADDR_W'(1);
		end else begin
			p.two  = 1'b1;
			p.step = 1'b1;
			if (lfsr_bit(s)) begin
				p.first  = base + ADDR_W'(1);
				p.second = base - ADDR_W'(1);
			end else begin
				p.first  = base - ADDR_W'(1);
				p.second = base + ADDR_W'(1);
			end
		end
		return p;
	endfunction

	eng_state_t        state_q, state_d;
	logic [ADDR_W-1:0] idx_q, idx_d;
	logic [COL_W-1:0]  col_q, col_d;
	logic [KIND_W-1:0] kind_q, kind_d;
	logic [ADDR_W-1:0] cand_q, cand_d;
	logic [ADDR_W-1:0] alt_q, alt_d;
	logic              has2_q, has2_d;
	logic [KIND_W-1:0] wkind_q, wkind_d;
	logic              wmark_q, wmark_d;
	logic [SEED_W-1:0] lfsr_q, lfsr_d;
	out_word_t         res_q, res_d;

	logic              g_we, g_re, m_we, m_re;
	logic [ADDR_W-1:0] g_waddr, g_raddr, m_waddr, m_raddr;
	logic [KIND_W-1:0] g_wdata, g_rdata;
	logic [0:0]        m_wdata, m_rdata;

	logic              addr_ok, bottom, next_cell;
	logic [ADDR_W-1:0] below, cmd_addr;
	side_t             sp_below, sp_here, sp;
	logic              use_below;

	fsgs_ram #(.WIDTH(KIND_W), .DEPTH(CELL_COUNT)) u_grid (
		.clk  (clk),
		.we   (g_we),
		.waddr(g_waddr),
		.wdata(g_wdata),
		.re   (g_re),
		.raddr(g_raddr),
		.rdata(g_rdata)
	);

	fsgs_ram #(.WIDTH(1), .DEPTH(CELL_COUNT)) u_marks (
		.clk  (clk),
		.we   (m_we),
		.waddr(m_waddr),
		.wdata(m_wdata),
		.re   (m_re),
		.raddr(m_raddr),
		.rdata(m_rdata)
	);

	assign addr_ok  = CMP_W'(cmd.cell_address) < CMP_W'(CELL_COUNT);
	assign cmd_addr = ADDR_W'(cmd.cell_address);
	assign bottom   = idx_q >= ADDR_W'(CELL_COUNT - GRID_WIDTH);
	assign below    = idx_q + ADDR_W'(GRID_WIDTH);
	assign sp_below = side_pick(below, col_q, lfsr_q);
	assign sp_here  = side_pick(idx_q, col_q, lfsr_q);
	assign sp       = use_below ? sp_below : sp_here;

	assign stat.ready     = state_q == ST_IDLE;
	assign stat.res_valid = state_q == ST_DONE;
	assign res            = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			idx_q   <= '0;
			col_q   <= '0;
			has2_q  <= 1'b0;
			wmark_q <= 1'b0;
			lfsr_q  <= SEED_RESET;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			col_q   <= col_d;
			has2_q  <= has2_d;
			wmark_q <= wmark_d;
			lfsr_q  <= lfsr_d;
		end
	end

	always_ff @(posedge clk) begin
		kind_q  <= kind_d;
		cand_q  <= cand_d;
		alt_q   <= alt_d;
		wkind_q <= wkind_d;
		res_q   <= res_d;
	end

	always_comb begin
		state_d   = state_q;
		idx_d     = idx_q;
		col_d     = col_q;
		kind_d    = kind_q;
		cand_d    = cand_q;
		alt_d     = alt_q;
		has2_d    = has2_q;
		wkind_d   = wkind_q;
		wmark_d   = wmark_q;
		lfsr_d    = lfsr_q;
		res_d     = res_q;
		g_we      = 1'b0;
		g_waddr   = idx_q;
		g_wdata   = KIND_AIR;
		g_re      = 1'b0;
		g_raddr   = idx_q;
		m_we      = 1'b0;
		m_waddr   = idx_q;
		m_wdata   = 1'b0;
		m_re      = 1'b0;
		m_raddr   = idx_q;
		next_cell = 1'b0;
		use_below = 1'b0;

		case (state_q)
			ST_INIT: begin
				// wipe grid and marks after reset
				g_we    = 1'b1;
				m_we    = 1'b1;
				idx_d   = idx_q + ADDR_W'(1);
				if (idx_q == ADDR_W'(CELL_COUNT - 1)) begin
					idx_d   = '0;
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					res_d.cell_kind_out = KIND_AIR;
					res_d.command_done  = 1'b1;
					case (cmd.opcode)
						OP_WRITE: begin
							g_we    = addr_ok;
							g_waddr = cmd_addr;
							g_wdata = cmd.cell_kind_in;
							state_d = ST_DONE;
						end
						OP_READ: begin
							g_re    = addr_ok;
							g_raddr = cmd_addr;
							state_d = addr_ok ? ST_RD_WAIT : ST_DONE;
						end
						OP_SWEEP: begin
							idx_d   = '0;
							state_d = ST_CLR;
						end
						default: begin
							res_d.command_done = 1'b0;
							state_d            = ST_DONE;
						end
					endcase
				end
			end
			ST_RD_WAIT: begin
				res_d.cell_kind_out = g_rdata;
				state_d             = ST_DONE;
			end
			ST_CLR: begin
				m_we  = 1'b1;
				idx_d = idx_q + ADDR_W'(1);
				if (idx_q == ADDR_W'(CELL_COUNT - 1)) begin
					idx_d   = ADDR_W'(CELL_COUNT - 1);
					col_d   = COL_W'(GRID_WIDTH - 1);
					state_d = ST_CUR_RD;
				end
			end
			ST_CUR_RD: begin
				g_re    = 1'b1;
				m_re    = 1'b1;
				state_d = ST_CUR_EV;
			end
			ST_CUR_EV: begin
				kind_d = g_rdata;
				if (m_rdata[0] || (g_rdata != KIND_SAND && g_rdata != KIND_WATER)) begin
					next_cell = 1'b1;
				end else if (bottom) begin
					if (g_rdata == KIND_SAND) begin
						next_cell = 1'b1;
					end else begin
						g_re    = 1'b1;
						g_raddr = sp.first;
						cand_d  = sp.first;
						alt_d   = sp.second;
						has2_d  = sp.two;
						if (sp.step) lfsr_d = {lfsr_bit(lfsr_q), lfsr_q[SEED_W-1:1]};
						state_d = ST_SIDE_EV;
					end
				end else begin
					g_re    = 1'b1;
					g_raddr = below;
					state_d = ST_BEL_EV;
				end
			end
			ST_BEL_EV: begin
				use_below = kind_q == KIND_SAND;
				if (g_rdata == KIND_AIR) begin
					g_we    = 1'b1;
					g_waddr = below;
					g_wdata = kind_q;
					m_we    = 1'b1;
					m_waddr = below;
					m_wdata = 1'b1;
					wkind_d = KIND_AIR;
					wmark_d = 1'b0;
					state_d = ST_WR_SRC;
				end else if (g_rdata == KIND_WATER && kind_q == KIND_SAND) begin
					// sand sinks through water, both cells marked
					g_we    = 1'b1;
					g_waddr = below;
					g_wdata = KIND_SAND;
					m_we    = 1'b1;
					m_waddr = below;
					m_wdata = 1'b1;
					wkind_d = KIND_WATER;
					wmark_d = 1'b1;
					state_d = ST_WR_SRC;
				end else begin
					g_re    = 1'b1;
					g_raddr = sp.first;
					cand_d  = sp.first;
					alt_d   = sp.second;
					has2_d  = sp.two;
					if (sp.step) lfsr_d = {lfsr_bit(lfsr_q), lfsr_q[SEED_W-1:1]};
					state_d = ST_SIDE_EV;
				end
			end
			ST_SIDE_EV: begin
				if (g_rdata == KIND_AIR) begin
					g_we    = 1'b1;
					g_waddr = cand_q;
					g_wdata = kind_q;
					m_we    = 1'b1;
					m_waddr = cand_q;
					m_wdata = 1'b1;
					wkind_d = KIND_AIR;
					wmark_d = 1'b0;
					state_d = ST_WR_SRC;
				end else if (has2_q) begin
					g_re    = 1'b1;
					g_raddr = alt_q;
					cand_d  = alt_q;
					has2_d  = 1'b0;
				end else begin
					next_cell = 1'b1;
				end
			end
			ST_WR_SRC: begin
				g_we      = 1'b1;
				g_wdata   = wkind_q;
				m_we      = wmark_q;
				m_wdata   = 1'b1;
				next_cell = 1'b1;
			end
			ST_DONE: begin
				if (res_take) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		if (next_cell) begin
			if (idx_q == '0) begin
				res_d.cell_kind_out = KIND_AIR;
				res_d.command_done  = 1'b1;
				state_d             = ST_DONE;
			end else begin
				idx_d   = idx_q - ADDR_W'(1);
				col_d   = (col_q == '0) ? COL_W'(GRID_WIDTH - 1) : col_q - COL_W'(1);
				state_d = ST_CUR_RD;
			end
		end

		if (lfsr_load) begin
			lfsr_d = (seed == '0) ? SEED_W'(1) : seed;
		end
	end

endmodule

[rtl/core/falling_sand_grid_sweep_unit.sv]
// ----------------------------------------------------------------------------
// falling_sand_grid_sweep_unit
// sand and water grid held in ram, with cell access and full update sweeps
// ----------------------------------------------------------------------------
//  port group   direction  handshake             word
//  in_*         input      in_valid / in_stall   in_word_t: opcode, address, kind
//  out_*        output     out_valid / out_stall out_word_t: kind read, done flag
//  apb          input      psel/penable/pwrite   random_seed at byte address 0
//
//  a sweep clears the marks of all 4096 cells, then updates each cell in turn,
//  last to first; the grid ram has a single read port
//  after reset the grid and marks are wiped, all 4096 cells, with in_stall high
//  a finished word sits in the output register while the next command runs
//  in_stall is high while a command is in the engine
// ----------------------------------------------------------------------------
module falling_sand_grid_sweep_unit
	import fsgs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_word_t              in_word,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_word_t             out_word,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	eng_stat_t         stat;
	out_word_t         res;
	logic              start, take, cfg_wr;
	logic [SEED_W-1:0] seed_q;
	logic              out_valid_q;
	out_word_t         out_word_q;

	// apb register file, a single seed word
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_SEED);
	assign prdata = (paddr[2] == REG_SEED) ? APB_DATA_W'(seed_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= SEED_RESET;
		end else if (cfg_wr) begin
			seed_q <= pwdata[SEED_W-1:0];
		end
	end

	// commands go in only when the engine sits idle
	assign in_stall = !stat.ready;
	assign start    = in_valid && !in_stall;

	// output register takes the engine result once it is free or draining
	assign take = stat.res_valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) out_word_q <= res;
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	fsgs_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.cmd      (in_word),
		.res_take (take),
		.lfsr_load(cfg_wr),
		.seed     (pwdata[SEED_W-1:0]),
		.stat     (stat),
		.res      (res)
	);

endmodule
